// ===== rtl/dual_motor_speed_to_pwm_mapper_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the dual motor speed to PWM mapper
// Clocked on aclk, disabled while aresetn is low. Define NO_ASSERTIONS to
// compile them away.
// ---------------------------------------------------------------------------
`ifndef DUAL_MOTOR_SPEED_TO_PWM_MAPPER_DEFINES_SVH
`define DUAL_MOTOR_SPEED_TO_PWM_MAPPER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define DMPWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dmpwm: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DMPWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dmpwm: assertion failed");

`else

`define DMPWM_ASSERT_NOW(label, ante, cons)
`define DMPWM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== rtl/dmpwm_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmpwm_pkg
// Widths, constants and shared types of the speed to PWM mapper.
// ---------------------------------------------------------------------------
package dmpwm_pkg;

    localparam int LANES      = 2;
    localparam int SPEED_W    = 16;
    localparam int FS_W       = 15;
    localparam int DUTY_W     = 7;
    localparam int PERIOD_W   = 16;
    localparam int PCT_W      = 8;
    localparam int MAG_W      = 17;
    localparam int NUM_W      = MAG_W + DUTY_W;
    localparam int REM_W      = 22;
    localparam int QUO_W      = 8;
    localparam int NUM_CELLS  = QUO_W;
    localparam int ACT_W      = PERIOD_W + DUTY_W;
    localparam int Y_W        = ACT_W - 2;
    localparam int RECIP_W    = 22;
    localparam int RECIP_SHIFT = 26;
    localparam int PROD_W     = Y_W + RECIP_W;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int S_DATA_W   = 32;
    localparam int M_DATA_W   = 56;

    localparam logic [FS_W-1:0]     DEFAULT_FULL_SCALE = 15'd350;
    localparam logic [DUTY_W-1:0]   PERCENT_FULL       = 7'd100;
    // ceil(2^26 / 25): floor(y / 25) for y below 2^21
    localparam logic [RECIP_W-1:0]  RECIP_25           = 22'd2684355;

    localparam logic [FS_W-1:0]     RST_FULL_SCALE = 15'd350;
    localparam logic [DUTY_W-1:0]   RST_MAX_DUTY   = 7'd80;
    localparam logic [PERIOD_W-1:0] RST_PERIOD     = 16'd1000;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FULL_SCALE = 3'd0,
        REG_MAX_DUTY   = 3'd1,
        REG_PWM_PERIOD = 3'd2,
        REG_LEFT_FWD   = 3'd3,
        REG_RIGHT_FWD  = 3'd4
    } reg_index_t;

    // Effective configuration as seen by the datapath
    typedef struct packed {
        logic [FS_W-1:0]     den;
        logic [DUTY_W-1:0]   maxd;
        logic [PERIOD_W-1:0] period;
        logic [LANES-1:0]    fwd_in1;
    } cfg_t;

    typedef struct packed {
        logic             neg;
        logic [REM_W-1:0] rem;
        logic [QUO_W-1:0] quo;
    } div_lane_t;

    typedef div_lane_t [LANES-1:0] div_data_t;

    // Pin and percent results carried alongside the compare arithmetic
    typedef struct packed {
        logic [LANES-1:0][PCT_W-1:0] pct;
        logic [LANES-1:0]            in_one;
        logic [LANES-1:0]            in_two;
        logic                        standby;
    } drive_t;

endpackage

// ===== rtl/dmpwm_cfg_regs.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmpwm_cfg_regs
// Configuration register file; presents the effective divisor, duty cap, period and polarity.
// ---------------------------------------------------------------------------
module dmpwm_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [dmpwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dmpwm_pkg::CFG_DATA_W-1:0]    cfg_data,
    output dmpwm_pkg::cfg_t                     cfg
);

    logic [dmpwm_pkg::FS_W-1:0]     full_scale_reg, full_scale_next;
    logic [dmpwm_pkg::DUTY_W-1:0]   max_duty_reg, max_duty_next;
    logic [dmpwm_pkg::PERIOD_W-1:0] period_reg, period_next;
    logic [dmpwm_pkg::LANES-1:0]    fwd_reg, fwd_next;

    always_comb begin
        full_scale_next = full_scale_reg;
        max_duty_next   = max_duty_reg;
        period_next     = period_reg;
        fwd_next        = fwd_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                dmpwm_pkg::REG_FULL_SCALE: full_scale_next = cfg_data[dmpwm_pkg::FS_W-1:0];
                dmpwm_pkg::REG_MAX_DUTY:   max_duty_next   = cfg_data[dmpwm_pkg::DUTY_W-1:0];
                dmpwm_pkg::REG_PWM_PERIOD: period_next     = cfg_data;
                dmpwm_pkg::REG_LEFT_FWD:   fwd_next[0]     = cfg_data[0];
                dmpwm_pkg::REG_RIGHT_FWD:  fwd_next[1]     = cfg_data[0];
                default: ; // drop writes beyond the register list
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_scale_reg <= dmpwm_pkg::RST_FULL_SCALE;
            max_duty_reg   <= dmpwm_pkg::RST_MAX_DUTY;
            period_reg     <= dmpwm_pkg::RST_PERIOD;
            fwd_reg        <= '1;
        end else begin
            full_scale_reg <= full_scale_next;
            max_duty_reg   <= max_duty_next;
            period_reg     <= period_next;
            fwd_reg        <= fwd_next;
        end
    end

    always_comb begin
        cfg.den     = (full_scale_reg == '0) ? dmpwm_pkg::DEFAULT_FULL_SCALE : full_scale_reg;
        cfg.maxd    = (max_duty_reg > dmpwm_pkg::PERCENT_FULL) ? dmpwm_pkg::PERCENT_FULL
                                                               : max_duty_reg;
        cfg.period  = period_reg;
        cfg.fwd_in1 = fwd_reg;
    end

endmodule

// ===== rtl/dmpwm_div_cell.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmpwm_div_cell
// One restoring division step for both lanes, with its own handshake stage.
// ---------------------------------------------------------------------------
module dmpwm_div_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  dmpwm_pkg::div_data_t          in_data,
    input  logic [dmpwm_pkg::REM_W-1:0]   divisor,
    output logic                          out_valid,
    input  logic                          out_ready,
    output dmpwm_pkg::div_data_t          out_data
);

    logic                 valid_reg, valid_next;
    dmpwm_pkg::div_data_t data_reg, data_next;
    logic                 take;

    always_comb begin
        for (int l = 0; l < dmpwm_pkg::LANES; l++) begin
            data_next[l].neg = in_data[l].neg;
            if (in_data[l].rem >= divisor) begin
                data_next[l].rem = in_data[l].rem - divisor;
                data_next[l].quo = {in_data[l].quo[dmpwm_pkg::QUO_W-2:0], 1'b1};
            end else begin
                data_next[l].rem = in_data[l].rem;
                data_next[l].quo = {in_data[l].quo[dmpwm_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== rtl/dual_motor_speed_to_pwm_mapper.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_motor_speed_to_pwm_mapper
// Signed left/right wheel speeds to duty percent, PWM compare and bridge pins.
// ---------------------------------------------------------------------------
// The block takes one speed pair per clock while the output side is not
// stalled and returns one result per pair, in order. Each speed is scaled
// by the duty cap over the full-scale speed with a row of eight
// restoring-division cells (one quotient bit per cell, both sides in
// parallel); the quotient is rounded half away from zero and clamped to
// the cap. The percent then sets the down-count compare, period minus
// period times percent over 100, the division by 100 being a shift and a
// reciprocal multiply. Every stage has its own valid bit, so a stalled
// output still lets the input side fill bubbles. Write the configuration
// registers only while no transfer is in flight.
// ---------------------------------------------------------------------------
`include "dual_motor_speed_to_pwm_mapper_defines.svh"

module dual_motor_speed_to_pwm_mapper (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dmpwm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [dmpwm_pkg::CFG_DATA_W-1:0]    cfg_data,
    // Speed input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] left_speed, [31:16] right_speed
    input  logic [dmpwm_pkg::S_DATA_W-1:0]      s_tdata,
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [15:0] left_compare, [31:16] right_compare, [32] left_in_one,
    // [33] left_in_two, [34] right_in_one, [35] right_in_two,
    // [36] standby_enable, [44:37] left_percent, [52:45] right_percent,
    // [55:53] zero
    output logic [dmpwm_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int LANES = dmpwm_pkg::LANES;
    localparam int NCELL = dmpwm_pkg::NUM_CELLS;

    dmpwm_pkg::cfg_t cfg;

    // Configuration registers; writes always accepted
    assign cfg_ready = 1'b1;

    dmpwm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // ------------------------------------------------------------------
    // Front stage: magnitude, sign and rounded dividend
    // ------------------------------------------------------------------
    logic                 a_valid_reg, a_valid_next;
    dmpwm_pkg::div_data_t a_data_reg, a_data_next;
    logic                 a_ready;
    logic [LANES-1:0][dmpwm_pkg::SPEED_W-1:0] spd;
    logic [LANES-1:0][dmpwm_pkg::MAG_W-1:0]   mag;
    logic [LANES-1:0][dmpwm_pkg::NUM_W-1:0]   num;

    assign spd[0] = s_tdata[dmpwm_pkg::SPEED_W-1:0];
    assign spd[1] = s_tdata[2*dmpwm_pkg::SPEED_W-1:dmpwm_pkg::SPEED_W];

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            mag[l] = spd[l][dmpwm_pkg::SPEED_W-1]
                   ? (~{spd[l][dmpwm_pkg::SPEED_W-1], spd[l]} + dmpwm_pkg::MAG_W'(1))
                   : {1'b0, spd[l]};
            // speed * cap + half divisor, so the division rounds half away from zero
            num[l] = dmpwm_pkg::NUM_W'(mag[l]) * dmpwm_pkg::NUM_W'(cfg.maxd)
                   + dmpwm_pkg::NUM_W'(cfg.den >> 1);
            a_data_next[l].neg = spd[l][dmpwm_pkg::SPEED_W-1];
            a_data_next[l].rem = num[l][dmpwm_pkg::REM_W-1:0];
            a_data_next[l].quo = '0;
        end
    end

    logic [NCELL:0]       cell_valid;
    logic [NCELL:0]       cell_ready;
    dmpwm_pkg::div_data_t cell_data [NCELL+1];

    assign s_tready     = !a_valid_reg || a_ready;
    assign a_ready      = cell_ready[0];
    assign a_valid_next = s_tready ? s_tvalid : a_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_data_reg <= a_data_next;
        end
    end

    // ------------------------------------------------------------------
    // Division chain: cell k tests the divisor shifted by NCELL-1-k
    // ------------------------------------------------------------------
    assign cell_valid[0] = a_valid_reg;
    assign cell_data[0]  = a_data_reg;

    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        dmpwm_div_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (cell_valid[k]),
            .in_ready  (cell_ready[k]),
            .in_data   (cell_data[k]),
            .divisor   (dmpwm_pkg::REM_W'(cfg.den) << (NCELL - 1 - k)),
            .out_valid (cell_valid[k+1]),
            .out_ready (cell_ready[k+1]),
            .out_data  (cell_data[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Stage B: clamp, signed percent, pins, period * |percent|
    // ------------------------------------------------------------------
    logic   b_valid_reg, b_valid_next, b_ready;
    dmpwm_pkg::drive_t b_drive_reg, b_drive_next;
    logic [LANES-1:0][dmpwm_pkg::ACT_W-1:0]  b_act_reg, b_act_next;
    logic [LANES-1:0][dmpwm_pkg::DUTY_W-1:0] pmag;
    logic [LANES-1:0]                        nz;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            pmag[l] = (cell_data[NCELL][l].quo > dmpwm_pkg::QUO_W'(cfg.maxd))
                    ? cfg.maxd : cell_data[NCELL][l].quo[dmpwm_pkg::DUTY_W-1:0];
            nz[l]   = (pmag[l] != '0);
            b_drive_next.pct[l] = cell_data[NCELL][l].neg
                                ? (dmpwm_pkg::PCT_W'(0) - dmpwm_pkg::PCT_W'(pmag[l]))
                                : dmpwm_pkg::PCT_W'(pmag[l]);
            // forward drives input one when the polarity bit is set
            b_drive_next.in_one[l] = nz[l] && (!cell_data[NCELL][l].neg == cfg.fwd_in1[l]);
            b_drive_next.in_two[l] = nz[l] && (!cell_data[NCELL][l].neg != cfg.fwd_in1[l]);
            b_act_next[l] = dmpwm_pkg::ACT_W'(cfg.period) * dmpwm_pkg::ACT_W'(pmag[l]);
        end
        // both sides at zero: stop, standby low
        b_drive_next.standby = |nz;
    end

    assign cell_ready[NCELL] = b_ready;
    assign b_valid_next      = b_ready ? cell_valid[NCELL] : b_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= b_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cell_valid[NCELL] && b_ready) begin
            b_drive_reg <= b_drive_next;
            b_act_reg   <= b_act_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: divide by 100 as (x >> 2) * ceil(2^26 / 25) >> 26
    // ------------------------------------------------------------------
    logic   c_valid_reg, c_valid_next, c_ready;
    dmpwm_pkg::drive_t c_drive_reg;
    logic [LANES-1:0][dmpwm_pkg::PROD_W-1:0] c_prod_reg, c_prod_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            c_prod_next[l] = dmpwm_pkg::PROD_W'(b_act_reg[l][dmpwm_pkg::ACT_W-1:2])
                           * dmpwm_pkg::PROD_W'(dmpwm_pkg::RECIP_25);
        end
    end

    assign b_ready      = !b_valid_reg || c_ready;
    assign c_valid_next = c_ready ? b_valid_reg : c_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else begin
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_valid_reg && c_ready) begin
            c_drive_reg <= b_drive_reg;
            c_prod_reg  <= c_prod_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register: compare = period - active ticks
    // ------------------------------------------------------------------
    logic   d_valid_reg, d_valid_next, d_ready;
    dmpwm_pkg::drive_t d_drive_reg;
    logic [LANES-1:0][dmpwm_pkg::PERIOD_W-1:0] d_cmp_reg, d_cmp_next;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            d_cmp_next[l] = cfg.period
                          - c_prod_reg[l][dmpwm_pkg::RECIP_SHIFT +: dmpwm_pkg::PERIOD_W];
        end
    end

    assign d_ready      = !d_valid_reg || m_tready;
    assign c_ready      = d_ready;
    assign d_valid_next = d_ready ? c_valid_reg : d_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else begin
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (c_valid_reg && d_ready) begin
            d_drive_reg <= c_drive_reg;
            d_cmp_reg   <= d_cmp_next;
        end
    end

    assign m_tvalid = d_valid_reg;
    assign m_tdata  = {3'b000,
                       d_drive_reg.pct[1], d_drive_reg.pct[0],
                       d_drive_reg.standby,
                       d_drive_reg.in_two[1], d_drive_reg.in_one[1],
                       d_drive_reg.in_two[0], d_drive_reg.in_one[0],
                       d_cmp_reg[1], d_cmp_reg[0]};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `DMPWM_ASSERT_NEXT(a_accept_lands, s_tvalid && s_tready, a_valid_reg)
    `DMPWM_ASSERT_NOW(a_pins_exclusive, m_tvalid,
        !(m_tdata[32] && m_tdata[33]) && !(m_tdata[34] && m_tdata[35]))
    `DMPWM_ASSERT_NOW(a_compare_in_period, m_tvalid,
        (d_cmp_reg[0] <= cfg.period) && (d_cmp_reg[1] <= cfg.period))
    `DMPWM_ASSERT_NOW(a_standby_matches, m_tvalid,
        d_drive_reg.standby == ((d_drive_reg.pct[0] != '0) || (d_drive_reg.pct[1] != '0)))

endmodule

// ===== sim/dual_motor_speed_to_pwm_mapper_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dual_motor_speed_to_pwm_mapper_test
// Self-checking bench for the speed pair to bridge command mapper.
// ---------------------------------------------------------------------------
// A short table of probe pairs runs at the reset settings first. Its obvious
// rows carry a typed-in command, and the rest are predicted. Twelve batches of
// random speed pairs follow, each under a fresh register setting. The corner
// settings come first and random ones after. Every accepted command is
// compared field by field against the oldest prediction. The sender and the
// receiver stall at random, with different weights, in the first two thirds.
// ---------------------------------------------------------------------------
module dual_motor_speed_to_pwm_mapper_test;
    import dmpwm_pkg::*;

    localparam int NUM_BATCHES  = 12;
    localparam int BATCH_ITEMS  = 111;
    localparam int SHOWN_ERRORS = 10;
    localparam int TAIL_CYCLES  = 24;

    // One result transfer, laid out exactly as m_tdata (lowest field last)
    typedef struct packed {
        logic [2:0]        pad;
        logic signed [7:0] right_pct;
        logic signed [7:0] left_pct;
        logic              standby;
        logic              right_in_two;
        logic              right_in_one;
        logic              left_in_two;
        logic              left_in_one;
        logic [15:0]       right_cmp;
        logic [15:0]       left_cmp;
    } bridge_cmd_t;

    typedef struct {
        logic [15:0] left;
        logic [15:0] right;
        bit          typed;
        bridge_cmd_t cmd;
    } probe_t;

    typedef struct {
        int fs;
        int duty;
        int period;
        int lfwd;
        int rfwd;
    } setting_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [S_DATA_W-1:0]    s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [M_DATA_W-1:0]    m_tdata;

    // Travel with s_tdata: a typed-in command replaces the prediction
    bit                     s_typed = 1'b0;
    bridge_cmd_t            s_typed_cmd = '0;

    // Register mirror, updated on each configuration transfer
    logic [FS_W-1:0]        cfg_full_scale = RST_FULL_SCALE;
    logic [DUTY_W-1:0]      cfg_max_duty = RST_MAX_DUTY;
    logic [PERIOD_W-1:0]    cfg_period = RST_PERIOD;
    logic                   cfg_left_fwd = 1'b1;
    logic                   cfg_right_fwd = 1'b1;

    bridge_cmd_t            pending_cmds[$];
    probe_t                 probes[$];
    int                     mismatches = 0;
    int                     send_gap_pct = 0;
    int                     recv_stall_pct = 0;

    dual_motor_speed_to_pwm_mapper u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Hard stop well beyond the slowest correct run
    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------------

    // Scale a speed to signed duty percent: round half away from zero, then
    // clamp to the cap (a cap above 100 counts as 100).
    function automatic int duty_of(logic [15:0] speed);
        int unsigned mag;
        int unsigned den;
        int unsigned cap;
        int unsigned q;
        mag = speed[15] ? (32'h10000 - speed) : speed;
        den = (cfg_full_scale == 0) ? DEFAULT_FULL_SCALE : cfg_full_scale;
        cap = (cfg_max_duty > PERCENT_FULL) ? PERCENT_FULL : cfg_max_duty;
        q = (mag * cap + den / 2) / den;
        if (q > cap) begin
            q = cap;
        end
        return speed[15] ? -int'(q) : int'(q);
    endfunction

    // Down-count compare: period less its active share
    function automatic logic [15:0] compare_of(int pct);
        int unsigned per;
        int unsigned mag;
        per = cfg_period;
        mag = (pct < 0) ? -pct : pct;
        return 16'(per - (per * mag) / PERCENT_FULL);
    endfunction

    // Drive input one on forward when the polarity bit says so, else input two
    function automatic logic [1:0] pins_of(int pct, logic fwd_in1);
        if (pct == 0) begin
            return 2'b00;
        end
        return ((pct > 0) == fwd_in1) ? 2'b01 : 2'b10;
    endfunction

    function automatic bridge_cmd_t map_speeds(logic [15:0] left, logic [15:0] right);
        bridge_cmd_t c;
        int          lp;
        int          rp;
        lp = duty_of(left);
        rp = duty_of(right);
        c = '0;
        c.left_cmp  = compare_of(lp);
        c.right_cmp = compare_of(rp);
        {c.left_in_two, c.left_in_one}   = pins_of(lp, cfg_left_fwd);
        {c.right_in_two, c.right_in_one} = pins_of(rp, cfg_right_fwd);
        c.standby   = (lp != 0) || (rp != 0);
        c.left_pct  = 8'(lp);
        c.right_pct = 8'(rp);
        return c;
    endfunction

    function automatic bridge_cmd_t outcome(int lcmp, int rcmp, bit l1, bit l2, bit r1,
                                            bit r2, bit sb, int lpct, int rpct);
        bridge_cmd_t c;
        c = '0;
        c.left_cmp  = 16'(lcmp);
        c.right_cmp = 16'(rcmp);
        c.left_in_one  = l1;
        c.left_in_two  = l2;
        c.right_in_one = r1;
        c.right_in_two = r2;
        c.standby   = sb;
        c.left_pct  = 8'(lpct);
        c.right_pct = 8'(rpct);
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Scoreboard: mirror register writes, queue a command per accepted speed
    // pair, and check each result transfer against the oldest one.
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        bridge_cmd_t got;
        bridge_cmd_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FULL_SCALE: cfg_full_scale = cfg_data[FS_W-1:0];
                    REG_MAX_DUTY:   cfg_max_duty   = cfg_data[DUTY_W-1:0];
                    REG_PWM_PERIOD: cfg_period     = cfg_data;
                    REG_LEFT_FWD:   cfg_left_fwd   = cfg_data[0];
                    REG_RIGHT_FWD:  cfg_right_fwd  = cfg_data[0];
                    default: ;  // unknown index: drop the write
                endcase
            end
            if (s_tvalid && s_tready) begin
                pending_cmds.push_back(s_typed ? s_typed_cmd
                                               : map_speeds(s_tdata[15:0], s_tdata[31:16]));
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (pending_cmds.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOWN_ERRORS) begin
                        $display("%0t: result transfer with nothing pending: %h", $realtime,
                                 m_tdata);
                    end
                end else begin
                    want = pending_cmds.pop_front();
                    if (got.left_cmp !== want.left_cmp || got.right_cmp !== want.right_cmp ||
                        got.left_in_one !== want.left_in_one ||
                        got.left_in_two !== want.left_in_two ||
                        got.right_in_one !== want.right_in_one ||
                        got.right_in_two !== want.right_in_two ||
                        got.standby !== want.standby || got.left_pct !== want.left_pct ||
                        got.right_pct !== want.right_pct || got.pad !== want.pad) begin
                        mismatches++;
                        if (mismatches <= SHOWN_ERRORS) begin
                            $display("%0t: mismatch", $realtime);
                            $display("  want cmp %0d/%0d pins %b%b/%b%b sb %b pct %0d/%0d pad %b",
                                     want.left_cmp, want.right_cmp, want.left_in_one,
                                     want.left_in_two, want.right_in_one, want.right_in_two,
                                     want.standby, want.left_pct, want.right_pct, want.pad);
                            $display("  got  cmp %0d/%0d pins %b%b/%b%b sb %b pct %0d/%0d pad %b",
                                     got.left_cmp, got.right_cmp, got.left_in_one,
                                     got.left_in_two, got.right_in_one, got.right_in_two,
                                     got.standby, got.left_pct, got.right_pct, got.pad);
                        end
                    end
                end
            end
        end
    end

    // Receiver: stall at the weight of the current phase
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Stimulus tasks
    // ---------------------------------------------------------------------

    // Present one speed pair and hold it until the transfer; leave valid high
    task automatic send_pair(logic [15:0] left, logic [15:0] right, bit typed,
                             bridge_cmd_t cmd);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid    <= 1'b1;
        s_tdata     <= {right, left};
        s_typed     <= typed;
        s_typed_cmd <= cmd;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Wait for a clock edge, then hold until every command has come back
    task automatic drain();
        @(posedge aclk);
        while (pending_cmds.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Write an unused index, then all registers; junk sits in the bits above each register's width
    task automatic apply_setting(setting_t st);
        cfg_write(CFG_INDEX_W'($urandom_range(REG_RIGHT_FWD + 1, (1 << CFG_INDEX_W) - 1)),
                  16'($urandom));
        cfg_write(REG_FULL_SCALE, {1'($urandom), 15'(st.fs)});
        cfg_write(REG_MAX_DUTY, {9'($urandom), 7'(st.duty)});
        cfg_write(REG_PWM_PERIOD, 16'(st.period));
        cfg_write(REG_LEFT_FWD, {15'($urandom), 1'(st.lfwd)});
        cfg_write(REG_RIGHT_FWD, {15'($urandom), 1'(st.rfwd)});
        cfg_valid <= 1'b0;
    endtask

    // Mix of raw words, values around the full-scale speed, values near zero
    // and the extremes
    function automatic logic [15:0] pick_speed();
        int          span;
        int          v;
        int unsigned roll;
        span = 2 * ((cfg_full_scale == 0) ? DEFAULT_FULL_SCALE : cfg_full_scale);
        if (span > 32767) begin
            span = 32767;
        end
        roll = $urandom_range(0, 99);
        if (roll < 35) begin
            return 16'($urandom);
        end else if (roll < 75) begin
            v = int'($urandom_range(0, 2 * span)) - span;
        end else if (roll < 90) begin
            v = int'($urandom_range(0, 8)) - 4;
        end else begin
            case ($urandom_range(0, 3))
                0:       v = -32768;
                1:       v = 32767;
                2:       v = span / 2;
                default: v = -(span / 2);
            endcase
        end
        return 16'(v);
    endfunction

    task automatic add_probe(int left, int right, bit typed, bridge_cmd_t cmd);
        probe_t p;
        p.left  = 16'(left);
        p.right = 16'(right);
        p.typed = typed;
        p.cmd   = cmd;
        probes.push_back(p);
    endtask

    // ---------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------
    initial begin
        setting_t st;
        int       hold_at;

        // Probe table at the reset settings (350 full scale, 80 %, period 1000)
        add_probe(0, 0, 1, outcome(1000, 1000, 0, 0, 0, 0, 0, 0, 0));             // stop
        add_probe(350, 350, 1, outcome(200, 200, 1, 0, 1, 0, 1, 80, 80));
        add_probe(-350, -350, 1, outcome(200, 200, 0, 1, 0, 1, 1, -80, -80));
        add_probe(32767, -32768, 1, outcome(200, 200, 1, 0, 0, 1, 1, 80, -80));
        add_probe(-32768, 32767, 1, outcome(200, 200, 0, 1, 1, 0, 1, -80, 80));
        add_probe(0, 350, 1, outcome(1000, 200, 0, 0, 1, 0, 1, 0, 80));         // left idle
        add_probe(-350, 0, 1, outcome(200, 1000, 0, 1, 0, 0, 1, -80, 0));       // right idle
        add_probe(2, -2, 0, '0);        // rounds to zero on both sides: stop
        add_probe(3, -3, 0, '0);
        add_probe(1, 0, 0, '0);
        add_probe(175, -175, 0, '0);
        add_probe(176, -176, 0, '0);
        add_probe(349, -349, 0, '0);
        add_probe(351, -351, 0, '0);
        add_probe(700, -700, 0, '0);
        add_probe(-32767, 1, 0, '0);
        add_probe(100, -100, 0, '0);
        add_probe(12345, -1, 0, '0);
        add_probe(-1, 1, 0, '0);
        add_probe(4, 5, 0, '0);

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_gap_pct   = 34;
        recv_stall_pct = 61;
        foreach (probes[i]) begin
            send_pair(probes[i].left, probes[i].right, probes[i].typed, probes[i].cmd);
        end
        s_tvalid <= 1'b0;
        s_typed  <= 1'b0;

        for (int k = 0; k < NUM_BATCHES; k++) begin
            // Receiver-heavy idling, then sender-heavy, then none at all
            if (k < NUM_BATCHES / 3) begin
                send_gap_pct   = 34;
                recv_stall_pct = 61;
            end else if (k < 2 * NUM_BATCHES / 3) begin
                send_gap_pct   = 61;
                recv_stall_pct = 34;
            end else begin
                send_gap_pct   = 0;
                recv_stall_pct = 0;
            end

            case (k)
                0: st = '{0, 80, 1000, 0, 1};         // full scale zero selects default
                1: st = '{1, 100, 65535, 1, 0};       // huge gain, clamps everywhere
                2: st = '{32767, 100, 65535, 0, 0};   // weakest gain
                3: st = '{200, 0, 1000, 1, 1};        // zero cap: always stop
                4: st = '{350, 127, 100, 1, 1};       // cap above 100
                5: st = '{1000, 101, 0, 0, 1};        // period zero
                6: st = '{35, 100, 1, 1, 0};          // shortest nonzero period
                default: begin
                    st.fs     = $urandom_range(0, 32767);
                    st.duty   = $urandom_range(0, 127);
                    st.period = $urandom_range(0, 65535);
                    st.lfwd   = $urandom_range(0, 1);
                    st.rfwd   = $urandom_range(0, 1);
                end
            endcase

            drain();
            apply_setting(st);

            hold_at = $urandom_range(1, BATCH_ITEMS - 1);
            for (int n = 0; n < BATCH_ITEMS; n++) begin
                // Once per batch let the pipeline run dry before the next pair
                if (n == hold_at) begin
                    s_tvalid <= 1'b0;
                    drain();
                end
                send_pair(pick_speed(), pick_speed(), 1'b0, '0);
            end
            s_tvalid <= 1'b0;
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0 && pending_cmds.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
